@@ rtl/spq_pkg.sv @@
// Shared types and constants for the scale pitch table quantizer.
package spq_pkg;

   localparam int ENTRY_INDEX_W = 7;
   localparam int NOTE_POS_W    = 23;
   localparam int RATIO_W       = 32;
   localparam int PITCH_W       = 32;

   // 1.0 in Q8.24.
   localparam logic [RATIO_W-1:0] ONE_Q24 = 32'h0100_0000;

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_NOTE  = 2'd1,
      OP_QDOWN = 2'd2,
      OP_QNEAR = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_END,
      ST_NOTE_A,
      ST_NOTE_B,
      ST_NOTE_C,
      ST_NOTE_D,
      ST_NOTE_E,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                      mapped;
      logic [RATIO_W-1:0]        ratio;
      logic signed [PITCH_W-1:0] pitch;
   } tbl_entry_type;

   typedef struct packed {
      logic [RATIO_W-1:0]        ratio_out;
      logic signed [PITCH_W-1:0] pitch_out;
      logic                      hit;
   } rsp_word_type;

endpackage

@@ rtl/scale_pitch_table_quantizer.sv @@
// One word in flight: a new word is taken once the previous result is in the output
// register. A quantize word reads the whole table, one table read per cycle through the
// single read port; a note query does two reads, a multiply and a round.
// Reset: synchronous; afterwards a clearing pass unmaps every entry, with req_ready low
// until it completes.
module scale_pitch_table_quantizer
   import spq_pkg::*;
#(
   parameter int TABLE_DEPTH    = 128,
   parameter int NOTE_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [ENTRY_INDEX_W-1:0]  req_entry_index,
   input  logic                      req_entry_mapped,
   input  logic [RATIO_W-1:0]        req_entry_ratio,
   input  logic signed [PITCH_W-1:0] req_entry_pitch,
   input  logic [NOTE_POS_W-1:0]     req_note_position,
   input  logic signed [PITCH_W-1:0] req_query_pitch,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RATIO_W-1:0]        rsp_ratio_out,
   output logic signed [PITCH_W-1:0] rsp_pitch_out,
   output logic                      rsp_hit
);

   localparam int IDX_W = $clog2(TABLE_DEPTH);

   // The table keeps the mapped flag, ratio and pitch of a note in one memory
   // word. Every lookup is carried out by reading that memory: a note query
   // reads its entry and the next one, a quantize word sweeps all entries in
   // ascending order and keeps the best match in registers.
   logic              mem_wr_en;
   logic [IDX_W-1:0]  mem_wr_addr;
   tbl_entry_type     mem_wr_data;
   logic              mem_rd_en;
   logic [IDX_W-1:0]  mem_rd_addr;
   tbl_entry_type     mem_rd_data;

   // Finished result handed to the output register.
   logic              res_valid;
   logic              res_ready;
   rsp_word_type      res_word;

   spq_table_mem #(
      .DEPTH  (TABLE_DEPTH),
      .ADDR_W (IDX_W)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // The engine accepts a word only when idle, so the table never sees a
   // write and a read of the same entry from overlapping words.
   spq_engine #(
      .TABLE_DEPTH    (TABLE_DEPTH),
      .NOTE_FRAC_BITS (NOTE_FRAC_BITS)
   ) u_engine (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_operation     (req_operation),
      .req_entry_index   (req_entry_index),
      .req_entry_mapped  (req_entry_mapped),
      .req_entry_ratio   (req_entry_ratio),
      .req_entry_pitch   (req_entry_pitch),
      .req_note_position (req_note_position),
      .req_query_pitch   (req_query_pitch),
      .mem_wr_en         (mem_wr_en),
      .mem_wr_addr       (mem_wr_addr),
      .mem_wr_data       (mem_wr_data),
      .mem_rd_en         (mem_rd_en),
      .mem_rd_addr       (mem_rd_addr),
      .mem_rd_data       (mem_rd_data),
      .res_valid         (res_valid),
      .res_ready         (res_ready),
      .res_word          (res_word)
   );

   // The output register lets the engine take the next word while the
   // previous result waits on rsp_ready.
   spq_rsp_stage u_rsp (
      .clock         (clock),
      .reset         (reset),
      .res_valid     (res_valid),
      .res_ready     (res_ready),
      .res_word      (res_word),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_ratio_out (rsp_ratio_out),
      .rsp_pitch_out (rsp_pitch_out),
      .rsp_hit       (rsp_hit)
   );

endmodule

@@ rtl/spq_table_mem.sv @@
// Note table memory: one write port, one read port with registered read data.
module spq_table_mem
   import spq_pkg::*;
#(
   parameter int DEPTH  = 128,
   parameter int ADDR_W = 7
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  tbl_entry_type     wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output tbl_entry_type     rd_data
);

   tbl_entry_type mem [DEPTH];
   tbl_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/spq_engine.sv @@
// Sequencer and datapath: table clear, entry writes, note lookup and quantize scans.
module spq_engine
   import spq_pkg::*;
#(
   parameter int TABLE_DEPTH    = 128,
   parameter int NOTE_FRAC_BITS = 16
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [1:0]                 req_operation,
   input  logic [ENTRY_INDEX_W-1:0]   req_entry_index,
   input  logic                       req_entry_mapped,
   input  logic [RATIO_W-1:0]         req_entry_ratio,
   input  logic signed [PITCH_W-1:0]  req_entry_pitch,
   input  logic [NOTE_POS_W-1:0]      req_note_position,
   input  logic signed [PITCH_W-1:0]  req_query_pitch,
   output logic                                 mem_wr_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]       mem_wr_addr,
   output tbl_entry_type                        mem_wr_data,
   output logic                                 mem_rd_en,
   output logic [$clog2(TABLE_DEPTH)-1:0]       mem_rd_addr,
   input  tbl_entry_type                        mem_rd_data,
   output logic                       res_valid,
   input  logic                       res_ready,
   output rsp_word_type               res_word
);

   localparam int IDX_W  = $clog2(TABLE_DEPTH);
   localparam int PROD_W = RATIO_W + 2 + NOTE_FRAC_BITS;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);
   localparam logic [63:0] NOTE_TOP = 64'(TABLE_DEPTH - 1) << NOTE_FRAC_BITS;
   localparam logic signed [PROD_W-1:0] HALF = PROD_W'(1) << (NOTE_FRAC_BITS - 1);

   state_type state_ff, state_in;

   logic [IDX_W-1:0]           clr_cnt_ff, clr_cnt_in;
   logic [IDX_W-1:0]           scan_cnt_ff, scan_cnt_in;
   logic                       rd_pend_ff, rd_pend_in;
   logic [IDX_W-1:0]           rd_idx_ff, rd_idx_in;
   op_type                     op_ff, op_in;
   logic signed [PITCH_W-1:0]  query_ff, query_in;
   logic [IDX_W-1:0]           note_idx_ff, note_idx_in;
   logic [NOTE_FRAC_BITS-1:0]  note_frac_ff, note_frac_in;
   logic                       note_top_ff, note_top_in;
   logic [RATIO_W-1:0]         a_ratio_ff, a_ratio_in;
   logic                       a_map_ff, a_map_in;
   logic                       b_map_ff, b_map_in;
   logic signed [RATIO_W:0]    diff_ff, diff_in;
   logic signed [PROD_W-1:0]   prod_ff, prod_in;
   logic [PITCH_W:0]           best_ff, best_in;
   logic [RATIO_W-1:0]         res_ratio_ff, res_ratio_in;
   logic signed [PITCH_W-1:0]  res_pitch_ff, res_pitch_in;
   logic                       res_hit_ff, res_hit_in;

   op_type                     req_op;
   logic                       accept;
   logic [63:0]                pos_wide;
   logic [63:0]                pos_clamp;
   logic [IDX_W-1:0]           pos_idx;
   logic signed [PITCH_W:0]    pdiff;
   logic [PITCH_W:0]           pabs;
   logic                       down_match;
   logic                       near_match;
   logic signed [PROD_W-1:0]   rnd;
   logic signed [PROD_W-1:0]   interp;

   assign req_op = op_type'(req_operation);
   assign accept = req_valid && req_ready;

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (clr_cnt_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               case (req_op)
                  OP_WRITE: state_in = ST_DONE;
                  OP_NOTE:  state_in = ST_NOTE_A;
                  default:  state_in = ST_SCAN;
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_cnt_ff == LAST_IDX) begin
               state_in = ST_SCAN_END;
            end
         end
         ST_SCAN_END: state_in = ST_DONE;
         ST_NOTE_A:   state_in = ST_NOTE_B;
         ST_NOTE_B:   state_in = ST_NOTE_C;
         ST_NOTE_C:   state_in = ST_NOTE_D;
         ST_NOTE_D:   state_in = ST_NOTE_E;
         ST_NOTE_E:   state_in = ST_DONE;
         ST_DONE: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   // State outputs: handshake and memory port control.
   always_comb begin
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = clr_cnt_ff;
      mem_wr_data = '0;
      mem_rd_en   = 1'b0;
      mem_rd_addr = scan_cnt_ff;
      case (state_ff)
         ST_CLEAR: begin
            mem_wr_en = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            mem_wr_addr = IDX_W'(req_entry_index);
            mem_wr_data = '{mapped: req_entry_mapped, ratio: req_entry_ratio,
                            pitch: req_entry_pitch};
            mem_wr_en   = req_valid && (req_op == OP_WRITE) &&
                          (32'(req_entry_index) < 32'(TABLE_DEPTH));
         end
         ST_SCAN: begin
            mem_rd_en = 1'b1;
         end
         ST_NOTE_A: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = note_idx_ff;
         end
         ST_NOTE_B: begin
            mem_rd_en   = 1'b1;
            mem_rd_addr = note_idx_ff + IDX_W'(1);
         end
         ST_DONE: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Note position clamp and split into entry index and fraction.
   always_comb begin
      pos_wide  = 64'(req_note_position);
      pos_clamp = (pos_wide > NOTE_TOP) ? NOTE_TOP : pos_wide;
      pos_idx   = IDX_W'(pos_clamp >> NOTE_FRAC_BITS);
   end

   // Per-entry compare for the scans.
   always_comb begin
      pdiff      = {mem_rd_data.pitch[PITCH_W-1], mem_rd_data.pitch} -
                   {query_ff[PITCH_W-1], query_ff};
      pabs       = pdiff[PITCH_W] ? (PITCH_W+1)'(-pdiff) : (PITCH_W+1)'(pdiff);
      down_match = mem_rd_data.mapped && (rd_idx_ff != '0) &&
                   (mem_rd_data.pitch <= query_ff);
      near_match = mem_rd_data.mapped && (!res_hit_ff || (pabs <= best_ff));
   end

   // Interpolation: a + round((b - a) * f / 2^F), same as the weighted sum.
   always_comb begin
      rnd    = prod_ff + HALF;
      interp = rnd >>> NOTE_FRAC_BITS;
   end

   always_comb begin
      clr_cnt_in   = clr_cnt_ff;
      scan_cnt_in  = scan_cnt_ff;
      rd_pend_in   = (state_ff == ST_SCAN);
      rd_idx_in    = scan_cnt_ff;
      op_in        = op_ff;
      query_in     = query_ff;
      note_idx_in  = note_idx_ff;
      note_frac_in = note_frac_ff;
      note_top_in  = note_top_ff;
      a_ratio_in   = a_ratio_ff;
      a_map_in     = a_map_ff;
      b_map_in     = b_map_ff;
      diff_in      = diff_ff;
      prod_in      = PROD_W'(diff_ff) * PROD_W'($signed({1'b0, note_frac_ff}));
      best_in      = best_ff;
      res_ratio_in = res_ratio_ff;
      res_pitch_in = res_pitch_ff;
      res_hit_in   = res_hit_ff;

      if (state_ff == ST_CLEAR) begin
         clr_cnt_in = clr_cnt_ff + IDX_W'(1);
      end

      if (accept) begin
         op_in        = req_op;
         query_in     = req_query_pitch;
         note_idx_in  = pos_idx;
         note_frac_in = NOTE_FRAC_BITS'(pos_clamp);
         note_top_in  = (pos_idx == LAST_IDX);
         scan_cnt_in  = '0;
         best_in      = '0;
         res_ratio_in = '0;
         res_pitch_in = (req_op == OP_QNEAR) ? $signed(ONE_Q24) : '0;
         res_hit_in   = 1'b0;
      end

      if (state_ff == ST_SCAN) begin
         scan_cnt_in = scan_cnt_ff + IDX_W'(1);
      end

      // Ascending scan: the last match seen is the highest index, which is
      // what quantize-down wants and gives quantize-nearest its tie rule.
      if (rd_pend_ff) begin
         if ((op_ff == OP_QDOWN) ? down_match : near_match) begin
            res_pitch_in = mem_rd_data.pitch;
            res_hit_in   = 1'b1;
            best_in      = pabs;
         end
      end

      if (state_ff == ST_NOTE_B) begin
         a_ratio_in = mem_rd_data.ratio;
         a_map_in   = mem_rd_data.mapped;
      end

      if (state_ff == ST_NOTE_C) begin
         b_map_in = mem_rd_data.mapped && !note_top_ff;
         diff_in  = $signed({1'b0, mem_rd_data.ratio}) - $signed({1'b0, a_ratio_ff});
      end

      if (state_ff == ST_NOTE_E) begin
         if (!a_map_ff) begin
            res_ratio_in = ONE_Q24;
            res_hit_in   = 1'b0;
         end else begin
            res_hit_in   = 1'b1;
            res_ratio_in = b_map_ff ? (a_ratio_ff + RATIO_W'(interp)) : a_ratio_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         clr_cnt_ff <= '0;
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         clr_cnt_ff <= clr_cnt_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_cnt_ff  <= scan_cnt_in;
      rd_idx_ff    <= rd_idx_in;
      op_ff        <= op_in;
      query_ff     <= query_in;
      note_idx_ff  <= note_idx_in;
      note_frac_ff <= note_frac_in;
      note_top_ff  <= note_top_in;
      a_ratio_ff   <= a_ratio_in;
      a_map_ff     <= a_map_in;
      b_map_ff     <= b_map_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      best_ff      <= best_in;
      res_ratio_ff <= res_ratio_in;
      res_pitch_ff <= res_pitch_in;
      res_hit_ff   <= res_hit_in;
   end

   assign res_word = '{ratio_out: res_ratio_ff, pitch_out: res_pitch_ff, hit: res_hit_ff};

`ifndef SYNTHESIS
   // A scan read in flight never meets a table write.
   a_no_write_during_scan: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> !mem_wr_en)
      else $error("table write while a scan read is pending");

   // The clearing pass keeps going until the top entry has been cleared.
   a_clear_runs_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CLEAR && clr_cnt_ff != LAST_IDX) |=> state_ff == ST_CLEAR)
      else $error("clearing pass ended early");

   // The final scan compare always follows the issue of the last address.
   a_scan_end_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_SCAN_END |-> $past(state_ff) == ST_SCAN && $past(scan_cnt_ff) == LAST_IDX)
      else $error("scan finished without reading the top entry");

   // A quantize query starts with no hit recorded.
   a_scan_starts_clean: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_op == OP_QDOWN || req_op == OP_QNEAR)) |=> !res_hit_ff)
      else $error("stale hit at scan start");
`endif

endmodule

@@ rtl/spq_rsp_stage.sv @@
// Result output register between the sequencer and the rsp channel.
module spq_rsp_stage
   import spq_pkg::*;
(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      res_valid,
   output logic                      res_ready,
   input  rsp_word_type              res_word,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [RATIO_W-1:0]        rsp_ratio_out,
   output logic signed [PITCH_W-1:0] rsp_pitch_out,
   output logic                      rsp_hit
);

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type word_ff;

   assign res_ready = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid && res_ready) begin
         word_ff <= res_word;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_ratio_out = word_ff.ratio_out;
   assign rsp_pitch_out = word_ff.pitch_out;
   assign rsp_hit       = word_ff.hit;

endmodule

@@ tb/spq_answer_check.sv @@
// Watches both channels of the pitch quantizer, predicts every answer and compares it.
`timescale 1ns / 100ps

module spq_answer_check
   import spq_pkg::*;
#(
   parameter int TABLE_DEPTH    = 128,
   parameter int NOTE_FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic                      req_ready,
   input  logic [1:0]                req_operation,
   input  logic [ENTRY_INDEX_W-1:0]  req_entry_index,
   input  logic                      req_entry_mapped,
   input  logic [RATIO_W-1:0]        req_entry_ratio,
   input  logic signed [PITCH_W-1:0] req_entry_pitch,
   input  logic [NOTE_POS_W-1:0]     req_note_position,
   input  logic signed [PITCH_W-1:0] req_query_pitch,
   input  logic                      rsp_valid,
   input  logic                      rsp_ready,
   input  logic [RATIO_W-1:0]        rsp_ratio_out,
   input  logic signed [PITCH_W-1:0] rsp_pitch_out,
   input  logic                      rsp_hit,
   output int                        mismatch_count,
   output int                        open_answers
);

   // Our own copy of the note table.
   bit                        note_mapped [TABLE_DEPTH];
   logic [RATIO_W-1:0]        note_ratio  [TABLE_DEPTH];
   logic signed [PITCH_W-1:0] note_pitch  [TABLE_DEPTH];

   rsp_word_type answers_due [$];
   rsp_word_type oldest;

   task automatic report_mismatch(string msg);
      $display("%0t: mismatch: %s", $realtime, msg);
      mismatch_count++;
   endtask

   function automatic rsp_word_type answer_for(op_type op, logic [NOTE_POS_W-1:0] position,
                                               logic signed [PITCH_W-1:0] query);
      rsp_word_type    ans;
      longint unsigned step, top, pos, frac, lo, hi;
      longint          span, best;
      int              slot;
      bit              found;
      ans  = '0;
      step = 64'd1 << NOTE_FRAC_BITS;
      top  = 64'(TABLE_DEPTH - 1) << NOTE_FRAC_BITS;
      best = 0;
      found = 1'b0;
      case (op)
         OP_NOTE: begin
            pos = position;
            if (pos > top)
               pos = top;
            slot = int'(pos >> NOTE_FRAC_BITS);
            frac = pos & (step - 1);
            ans.ratio_out = ONE_Q24;
            if (note_mapped[slot]) begin
               ans.hit = 1'b1;
               // The slot past the top of the table never counts as mapped.
               if (slot + 1 < TABLE_DEPTH && note_mapped[slot + 1]) begin
                  lo = note_ratio[slot];
                  hi = note_ratio[slot + 1];
                  ans.ratio_out = RATIO_W'((lo * (step - frac) + hi * frac + (step >> 1))
                                           >> NOTE_FRAC_BITS);
               end else begin
                  ans.ratio_out = note_ratio[slot];
               end
            end
         end
         OP_QDOWN: begin
            // Slot 0 is never a candidate for rounding down.
            for (int i = TABLE_DEPTH - 1; i > 0; i--) begin
               if (!found && note_mapped[i] && note_pitch[i] <= query) begin
                  found         = 1'b1;
                  ans.pitch_out = note_pitch[i];
                  ans.hit       = 1'b1;
               end
            end
         end
         OP_QNEAR: begin
            ans.pitch_out = ONE_Q24;
            // Equal distance goes to the higher slot, hence the <=.
            for (int i = 0; i < TABLE_DEPTH; i++) begin
               if (note_mapped[i]) begin
                  span = longint'(note_pitch[i]) - longint'(query);
                  if (span < 0)
                     span = -span;
                  if (!ans.hit || span <= best) begin
                     best          = span;
                     ans.pitch_out = note_pitch[i];
                     ans.hit       = 1'b1;
                  end
               end
            end
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < TABLE_DEPTH; i++)
            note_mapped[i] = 1'b0;
         answers_due.delete();
      end else begin
         // A result accepted together with a new word belongs to an older word.
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               report_mismatch($sformatf("result with nothing pending: ratio %h pitch %h hit %b",
                                         rsp_ratio_out, rsp_pitch_out, rsp_hit));
            end else begin
               oldest = answers_due.pop_front();
               if (rsp_ratio_out !== oldest.ratio_out)
                  report_mismatch($sformatf("ratio_out %h, expected %h",
                                            rsp_ratio_out, oldest.ratio_out));
               if (rsp_pitch_out !== oldest.pitch_out)
                  report_mismatch($sformatf("pitch_out %h, expected %h",
                                            rsp_pitch_out, oldest.pitch_out));
               if (rsp_hit !== oldest.hit)
                  report_mismatch($sformatf("hit %b, expected %b", rsp_hit, oldest.hit));
            end
         end
         if (req_valid && req_ready) begin
            answers_due.push_back(answer_for(op_type'(req_operation), req_note_position,
                                             req_query_pitch));
            if (op_type'(req_operation) == OP_WRITE && req_entry_index < TABLE_DEPTH) begin
               note_mapped[req_entry_index] = req_entry_mapped;
               note_ratio[req_entry_index]  = req_entry_ratio;
               note_pitch[req_entry_index]  = req_entry_pitch;
            end
         end
      end
      open_answers = answers_due.size();
   end

endmodule

@@ tb/tb_scale_pitch_table_quantizer.sv @@
// Top level of the pitch quantizer testbench: clock, reset, word stimulus and verdict.
`timescale 1ns / 100ps

module tb_scale_pitch_table_quantizer;
   import spq_pkg::*;

   localparam int TABLE_DEPTH    = 128;
   localparam int NOTE_FRAC_BITS = 16;
   localparam int RANDOM_WORDS   = 2000;
   // The channels stay quiet while a quantize word reads the whole table and during the
   // clearing pass after reset; receiver stalls and sender gaps add to that.
   localparam int QUIET_LIMIT    = 3000;

   logic                      clock             = 1'b0;
   logic                      reset             = 1'b1;
   logic                      req_valid         = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_operation     = '0;
   logic [ENTRY_INDEX_W-1:0]  req_entry_index   = '0;
   logic                      req_entry_mapped  = 1'b0;
   logic [RATIO_W-1:0]        req_entry_ratio   = '0;
   logic signed [PITCH_W-1:0] req_entry_pitch   = '0;
   logic [NOTE_POS_W-1:0]     req_note_position = '0;
   logic signed [PITCH_W-1:0] req_query_pitch   = '0;
   logic                      rsp_valid;
   logic                      rsp_ready         = 1'b0;
   logic [RATIO_W-1:0]        rsp_ratio_out;
   logic signed [PITCH_W-1:0] rsp_pitch_out;
   logic                      rsp_hit;

   int mismatch_count;
   int open_answers;
   int quiet_cycles = 0;

   // Sender burst bookkeeping and the receiver's stall pattern.
   int burst_left   = 0;
   int ready_mode   = 0;
   int ready_left   = 0;
   int ready_phase  = 0;

   always #5 clock = ~clock;

   scale_pitch_table_quantizer #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .NOTE_FRAC_BITS(NOTE_FRAC_BITS)
   ) i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_entry_mapped (req_entry_mapped),
      .req_entry_ratio  (req_entry_ratio),
      .req_entry_pitch  (req_entry_pitch),
      .req_note_position(req_note_position),
      .req_query_pitch  (req_query_pitch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ratio_out    (rsp_ratio_out),
      .rsp_pitch_out    (rsp_pitch_out),
      .rsp_hit          (rsp_hit)
   );

   spq_answer_check #(
      .TABLE_DEPTH   (TABLE_DEPTH),
      .NOTE_FRAC_BITS(NOTE_FRAC_BITS)
   ) i_answer_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_operation    (req_operation),
      .req_entry_index  (req_entry_index),
      .req_entry_mapped (req_entry_mapped),
      .req_entry_ratio  (req_entry_ratio),
      .req_entry_pitch  (req_entry_pitch),
      .req_note_position(req_note_position),
      .req_query_pitch  (req_query_pitch),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_ratio_out    (rsp_ratio_out),
      .rsp_pitch_out    (rsp_pitch_out),
      .rsp_hit          (rsp_hit),
      .mismatch_count   (mismatch_count),
      .open_answers     (open_answers)
   );

   // The receiver switches between three habits: always ready, randomly ready with a
   // chance of three in four, and a fixed repeating stall pattern. Each habit lasts
   // a random stretch, so result words meet stalls at every point of their wait.
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(20, 300);
      end else begin
         ready_left <= ready_left - 1;
      end
      ready_phase <= (ready_phase == 8) ? 0 : ready_phase + 1;
      case (ready_mode)
         0:       rsp_ready <= 1'b1;
         1:       rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= (ready_phase >= 5);
      endcase
   end

   // The watchdog ends a run in which neither channel has moved a word for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no word moved for %0d cycles", $realtime, QUIET_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Pitches mostly sit on a coarse grid near zero so that equal pitches, exact matches
   // and equal distances turn up often; the rest are the extremes or fully random.
   function automatic logic signed [PITCH_W-1:0] pick_pitch();
      case ($urandom_range(0, 5))
         0:       return PITCH_W'($urandom);
         1:       return $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
         default: return PITCH_W'((int'($urandom_range(0, 48)) - 24) * 32'sd1048576);
      endcase
   endfunction

   // Note positions favor whole and nearly whole notes; fully random ones also land
   // above the top entry and get clamped.
   function automatic logic [NOTE_POS_W-1:0] pick_position();
      case ($urandom_range(0, 5))
         0:       return NOTE_POS_W'($urandom);
         1:       return {7'($urandom_range(0, TABLE_DEPTH - 1)), 16'h0000};
         2:       return {7'($urandom_range(0, TABLE_DEPTH - 1)), 16'hFFFF};
         default: return {7'($urandom_range(0, TABLE_DEPTH - 1)), 16'($urandom)};
      endcase
   endfunction

   // Presents one word and returns at the edge that accepts it. The sender works in
   // bursts; between bursts valid drops for a random gap, which is zero now and then
   // so that long back-to-back stretches occur too. Ready is looked at on the falling
   // edge, where nothing is changing.
   task automatic send_word(op_type op, logic [ENTRY_INDEX_W-1:0] index, logic mapped,
                            logic [RATIO_W-1:0] ratio, logic signed [PITCH_W-1:0] pitch,
                            logic [NOTE_POS_W-1:0] position,
                            logic signed [PITCH_W-1:0] query);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_entry_index   <= index;
      req_entry_mapped  <= mapped;
      req_entry_ratio   <= ratio;
      req_entry_pitch   <= pitch;
      req_note_position <= position;
      req_query_pitch   <= query;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
   endtask

   // Holds the sender back until every word sent so far has its result.
   task automatic wait_all_answered();
      req_valid  <= 1'b0;
      burst_left = 0;
      do @(negedge clock); while (open_answers != 0);
      @(posedge clock);
   endtask

   initial begin
      int     map_percent;
      int     roll;
      op_type op;
      map_percent = 50;

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // With an empty table every lookup misses: nearest gives 1.0, down gives zero
      // and a note gives 1.0.
      send_word(OP_QNEAR, 0, 0, 0, 0, 0, 0);
      send_word(OP_QDOWN, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF);
      send_word(OP_NOTE, 0, 0, 0, 0, 0, 0);

      // Entry 0 at the extremes: rounding down skips it, nearest finds it from the far
      // end of the pitch range.
      send_word(OP_WRITE, 0, 1, 32'hFFFF_FFFF, 32'sh8000_0000, 0, 0);
      send_word(OP_QDOWN, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF);
      send_word(OP_QNEAR, 0, 0, 0, 0, 0, 32'sh7FFF_FFFF);

      // Interpolation between the largest and smallest ratios, then a mapped note
      // whose upper neighbor is not mapped.
      send_word(OP_WRITE, 1, 1, 32'h0000_0000, 32'sh7FFF_FFFF, 0, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h00_8000, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h00_FFFF, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h01_0000, 0);

      // The top entry: clamped positions, the exact top, and interpolation just below it.
      send_word(OP_WRITE, 127, 1, 32'h1234_5678, 32'sh0100_0000, 0, 0);
      send_word(OP_WRITE, 126, 1, 32'hFFFF_FFFF, 32'sh0200_0000, 0, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h7F_FFFF, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h7F_0000, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h7E_FFFF, 0);

      // Unmap the low entries and set up a tie for nearest in which the higher slot
      // holds the lower pitch.
      send_word(OP_WRITE, 0, 0, 0, 0, 0, 0);
      send_word(OP_WRITE, 1, 0, 32'hFFFF_FFFF, 32'shFFFF_FFFF, 0, 0);
      send_word(OP_WRITE, 3, 1, 32'h0180_0000, 32'sd300, 0, 0);
      send_word(OP_WRITE, 5, 1, 32'h0200_0000, 32'sd100, 0, 0);
      send_word(OP_QNEAR, 0, 0, 0, 0, 0, 32'sd200);
      send_word(OP_QDOWN, 0, 0, 0, 0, 0, 32'sd100);
      send_word(OP_QDOWN, 0, 0, 0, 0, 0, 32'sd99);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h02_1234, 0);
      send_word(OP_NOTE, 0, 0, 0, 0, 23'h03_4000, 0);
      send_word(OP_QNEAR, 0, 0, 0, 0, 0, 32'sh8000_0000);

      // Random words. The share of mapped writes changes every few hundred words, so
      // the table swings between sparse, where lookups often miss, and dense, where
      // notes interpolate and the searches compete among many entries.
      for (int n = 0; n < RANDOM_WORDS; n++) begin
         if (n % 250 == 0) begin
            case ($urandom_range(0, 2))
               0:       map_percent = 10;
               1:       map_percent = 50;
               default: map_percent = 90;
            endcase
         end
         if (n == RANDOM_WORDS / 2 || $urandom_range(0, 199) == 0)
            wait_all_answered();
         roll = $urandom_range(0, 99);
         if (roll < 40)
            op = OP_WRITE;
         else if (roll < 65)
            op = OP_NOTE;
         else if (roll < 82)
            op = OP_QDOWN;
         else
            op = OP_QNEAR;
         // Queries land on the grid or halfway between grid points to force ties.
         send_word(op, ENTRY_INDEX_W'($urandom), ($urandom_range(0, 99) < map_percent),
                   ($urandom_range(0, 7) == 0) ? {RATIO_W{$urandom_range(0, 1) == 1}}
                                               : RATIO_W'($urandom),
                   pick_pitch(), pick_position(),
                   pick_pitch() + ($urandom_range(0, 1) ? 32'sh0008_0000 : 32'sh0));
      end

      // Drain, then give any stray result time to show up.
      wait_all_answered();
      repeat (TABLE_DEPTH + 10) @(posedge clock);

      if (mismatch_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
